// File: hw/rtl/pmef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmef_pkg
// Shared widths, register codes and the per-cell state layout of the
// per-sensor median and low-pass filter.
// ----------------------------------------------------------------------------
package pmef_pkg;

	localparam int SAMPLE_W      = 12;
	localparam int INDEX_W       = 8;
	localparam int FILTERED_W    = 20;
	localparam int OUT_FRAC_W    = 8;
	localparam int FRAC_W        = 16;
	localparam int SMOOTH_W      = SAMPLE_W + FRAC_W;
	localparam int ALPHA_W       = 17;
	localparam int WIN_W         = 3;
	localparam int POINT_W       = 9;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 17;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h04000;
	localparam logic [WIN_W-1:0]   WIN_RESET   = 3'd1;

	localparam int MAX_SENSORS_DEF = 256;
	localparam int MEDIAN_MAX_DEF  = 5;

	// result queue behind the pipeline
	localparam int RESULT_DEPTH = 4;
	localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FILTER_ENABLE = 2'd0,
		CFG_MEDIAN_WINDOW = 2'd1,
		CFG_ALPHA         = 2'd2,
		CFG_POINT_COUNT   = 2'd3
	} cfg_reg_t;

	// per-cell bookkeeping kept next to the sample ring in one memory row
	typedef struct packed {
		logic [WIN_W-1:0]    fill;
		logic [WIN_W-1:0]    cursor;
		logic                started;
		logic [SMOOTH_W-1:0] smoothed;
	} cell_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/per_sensor_median_ema_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_sensor_median_ema_filter
// Per-cell median and one-pole low-pass filter for converter samples.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and gives one result per
// request, in order. A request's result passes stage 1 and stage 2 into the
// result queue; up to four requests and results may be in flight
// or waiting. Each cell's ring, fill count, cursor and low-pass value share
// one memory row: stage 1 gets the row (forwarded from the two requests ahead
// when they hit the same cell) and runs the ring update and median, stage 2
// runs the low-pass multiply and writes the row back, so the memory's single
// write port and the stage-2 low-pass loop set the rate of one per cycle.
// After reset and after every register write the block clears the memory,
// one row per cycle, up to row MAX_SENSORS-1; requests are held off meanwhile.
// Filtered values are Q12.8; bypassed samples come back shifted left by 8.
// ----------------------------------------------------------------------------
module per_sensor_median_ema_filter
	import pmef_pkg::*;
#(
	parameter int MAX_SENSORS = MAX_SENSORS_DEF,
	parameter int MEDIAN_MAX  = MEDIAN_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic [INDEX_W-1:0]     sensor_index,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [FILTERED_W-1:0]  filtered,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ADDR_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int RING_W  = MEDIAN_MAX * SAMPLE_W;
	localparam int STATE_W = $bits(cell_state_t);
	localparam int ROW_W   = RING_W + STATE_W;
	localparam int OCC_W   = $clog2(RESULT_DEPTH + 3);

	typedef logic [MEDIAN_MAX-1:0][SAMPLE_W-1:0] ring_t;

	// configuration
	logic                filter_enable_q;
	logic [WIN_W-1:0]    median_window_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [POINT_W-1:0]  point_count_q;
	logic                cfg_accept;
	logic [WIN_W-1:0]    win;
	logic [ALPHA_W-1:0]  alpha_sat;

	// clearing pass
	logic                clearing_q;
	logic [ADDR_W-1:0]   clr_addr_q;

	// request side
	logic                req_accept;
	logic                bypass_in;
	logic [OCC_W-1:0]    occupancy;
	logic [RESULT_CNT_W-1:0] res_count;

	// memory
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [ROW_W-1:0]    mem_wdata;
	logic [ROW_W-1:0]    mem_rdata;
	ring_t               rd_ring;
	cell_state_t         rd_state;

	// stage 1
	logic                valid_s1;
	logic                bypass_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                hit_s2_s1;
	logic                hit_wb_s1;
	ring_t               ring_prev;
	cell_state_t         state_prev;
	ring_t               ring_next;
	logic [WIN_W-1:0]    fill_next;
	logic [WIN_W-1:0]    cursor_next;
	logic [SAMPLE_W-1:0] median_next;

	// stage 2
	logic                valid_s2;
	logic                bypass_s2;
	logic [SAMPLE_W-1:0] sample_s2;
	logic [ADDR_W-1:0]   addr_s2;
	ring_t               ring_s2;
	cell_state_t         state_s2;
	logic [SAMPLE_W-1:0] median_s2;
	logic                hit_wb_s2;
	logic                started_prev;
	logic [SMOOTH_W-1:0] smoothed_prev;
	logic [SMOOTH_W-1:0] smoothed_new;
	cell_state_t         state_wr;
	logic                we_s2;
	logic [FILTERED_W-1:0] result;

	// last row written back
	logic                wb_valid_q;
	logic [ADDR_W-1:0]   wb_addr_q;
	ring_t               wb_ring_q;
	cell_state_t         wb_state_q;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			median_window_q <= WIN_RESET;
			alpha_q         <= ALPHA_RESET;
			point_count_q   <= '0;
		end else if (cfg_accept) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				CFG_MEDIAN_WINDOW: median_window_q <= cfg_data[WIN_W-1:0];
				CFG_ALPHA:         alpha_q         <= cfg_data[ALPHA_W-1:0];
				CFG_POINT_COUNT:   point_count_q   <= cfg_data[POINT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign win       = (32'(median_window_q) > MEDIAN_MAX) ? WIN_W'(MEDIAN_MAX) : median_window_q;
	assign alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	// ------------------------------------------------------------------
	// clearing pass over the memory
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (cfg_accept) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(MAX_SENSORS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// request acceptance: never more in flight than the result queue holds
	// ------------------------------------------------------------------
	assign occupancy  = OCC_W'(valid_s1) + OCC_W'(valid_s2) + OCC_W'(res_count);
	assign req_stall  = clearing_q || (occupancy >= OCC_W'(RESULT_DEPTH));
	assign req_accept = req_valid && !req_stall;
	assign bypass_in  = !filter_enable_q || (POINT_W'(sensor_index) >= point_count_q) ||
		(32'(sensor_index) >= MAX_SENSORS);

	// ------------------------------------------------------------------
	// row memory
	// ------------------------------------------------------------------
	assign mem_we    = clearing_q || we_s2;
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s2;
	assign mem_wdata = clearing_q ? '0 : {ring_s2, state_wr};

	pmef_row_mem #(
		.DEPTH  (MAX_SENSORS),
		.ADDR_W (ADDR_W),
		.ROW_W  (ROW_W)
	) u_row_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (req_accept),
		.raddr (ADDR_W'(sensor_index)),
		.rdata (mem_rdata)
	);

	assign rd_ring  = mem_rdata[ROW_W-1:STATE_W];
	assign rd_state = cell_state_t'(mem_rdata[STATE_W-1:0]);

	// ------------------------------------------------------------------
	// stage 1: forward the row, update ring, take the median
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			bypass_s1 <= bypass_in;
			sample_s1 <= sample;
			addr_s1   <= ADDR_W'(sensor_index);
		end
	end

	assign hit_s2_s1 = valid_s2 && !bypass_s2 && (addr_s2 == addr_s1);
	assign hit_wb_s1 = wb_valid_q && (wb_addr_q == addr_s1);

	// ring fields from the request in stage 2 are the newest; its low-pass
	// value is picked up from the write-back register in stage 2
	always_comb begin
		ring_prev  = rd_ring;
		state_prev = rd_state;
		if (hit_wb_s1) begin
			ring_prev  = wb_ring_q;
			state_prev = wb_state_q;
		end
		if (hit_s2_s1) begin
			ring_prev         = ring_s2;
			state_prev.fill   = state_s2.fill;
			state_prev.cursor = state_s2.cursor;
		end
	end

	pmef_ring_median #(
		.MEDIAN_MAX (MEDIAN_MAX)
	) u_ring_median (
		.ring_in    (ring_prev),
		.fill_in    (state_prev.fill),
		.cursor_in  (state_prev.cursor),
		.sample     (sample_s1),
		.win        (win),
		.ring_out   (ring_next),
		.fill_out   (fill_next),
		.cursor_out (cursor_next),
		.median     (median_next)
	);

	// ------------------------------------------------------------------
	// stage 2: low-pass, write back, result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			bypass_s2 <= bypass_s1;
			sample_s2 <= sample_s1;
			addr_s2   <= addr_s1;
			ring_s2   <= ring_next;
			state_s2  <= '{fill: fill_next, cursor: cursor_next,
				started: state_prev.started, smoothed: state_prev.smoothed};
			median_s2 <= median_next;
		end
	end

	assign hit_wb_s2     = wb_valid_q && (wb_addr_q == addr_s2);
	assign started_prev  = hit_wb_s2 ? wb_state_q.started : state_s2.started;
	assign smoothed_prev = hit_wb_s2 ? wb_state_q.smoothed : state_s2.smoothed;

	pmef_lowpass u_lowpass (
		.median        (median_s2),
		.started       (started_prev),
		.smoothed_prev (smoothed_prev),
		.alpha         (alpha_sat),
		.smoothed_next (smoothed_new)
	);

	assign state_wr = '{fill: state_s2.fill, cursor: state_s2.cursor,
		started: 1'b1, smoothed: smoothed_new};
	assign we_s2    = valid_s2 && !bypass_s2;
	assign result   = bypass_s2 ? {sample_s2, OUT_FRAC_W'(0)}
		: smoothed_new[SMOOTH_W-1 -: FILTERED_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
		end else if (cfg_accept || clearing_q) begin
			wb_valid_q <= 1'b0;
		end else if (we_s2) begin
			wb_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_s2) begin
			wb_addr_q  <= addr_s2;
			wb_ring_q  <= ring_s2;
			wb_state_q <= state_wr;
		end
	end

	pmef_result_fifo #(
		.DEPTH (RESULT_DEPTH)
	) u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data (result),
		.valid     (res_valid),
		.stall     (res_stall),
		.data      (filtered),
		.count     (res_count)
	);

endmodule
`default_nettype wire

// File: hw/rtl/pmef_row_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmef_row_mem
// One-write, one-read synchronous memory holding one row per sensor cell,
// read data registered.
// ----------------------------------------------------------------------------
module pmef_row_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int ROW_W  = 95
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [ROW_W-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [ROW_W-1:0]  rdata
);

	logic [ROW_W-1:0] mem [DEPTH];
	logic [ROW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/pmef_ring_median.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmef_ring_median
// Puts a sample into a cell's ring, advances fill count and cursor, and
// picks the median of the filled entries by parallel ranking, if win > 1.
// ----------------------------------------------------------------------------
module pmef_ring_median
	import pmef_pkg::*;
#(
	parameter int MEDIAN_MAX = MEDIAN_MAX_DEF
) (
	input  logic [MEDIAN_MAX-1:0][SAMPLE_W-1:0] ring_in,
	input  logic [WIN_W-1:0]                    fill_in,
	input  logic [WIN_W-1:0]                    cursor_in,
	input  logic [SAMPLE_W-1:0]                 sample,
	input  logic [WIN_W-1:0]                    win,
	output logic [MEDIAN_MAX-1:0][SAMPLE_W-1:0] ring_out,
	output logic [WIN_W-1:0]                    fill_out,
	output logic [WIN_W-1:0]                    cursor_out,
	output logic [SAMPLE_W-1:0]                 median
);

	logic [WIN_W-1:0]                    cnt;
	logic [WIN_W-1:0]                    cur;
	logic [WIN_W-1:0]                    cur_inc;
	logic [MEDIAN_MAX-1:0][SAMPLE_W-1:0] ring_wr;
	logic [WIN_W-1:0]                    rank [MEDIAN_MAX];
	logic [SAMPLE_W-1:0]                 med;

	always_comb begin
		cnt = fill_in;
		if (cnt < win) begin
			cnt = cnt + WIN_W'(1);
		end
		if (cnt > win) begin
			cnt = win;
		end
		cur = (cursor_in >= win) ? '0 : cursor_in;
		cur_inc = cur + WIN_W'(1);
		if (cur_inc >= win) begin
			cur_inc = '0;
		end

		for (int i = 0; i < MEDIAN_MAX; i++) begin
			ring_wr[i] = (cur == WIN_W'(i)) ? sample : ring_in[i];
		end

		// rank = number of filled entries ordered ahead, ties broken by slot
		for (int i = 0; i < MEDIAN_MAX; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MEDIAN_MAX; j++) begin
				if ((WIN_W'(j) < cnt) && ((ring_wr[j] < ring_wr[i]) ||
						((ring_wr[j] == ring_wr[i]) && (j < i)))) begin
					rank[i] = rank[i] + WIN_W'(1);
				end
			end
		end

		med = '0;
		for (int i = 0; i < MEDIAN_MAX; i++) begin
			if ((WIN_W'(i) < cnt) && (rank[i] == (cnt >> 1))) begin
				med = ring_wr[i];
			end
		end

		if (win > WIN_W'(1)) begin
			ring_out   = ring_wr;
			fill_out   = cnt;
			cursor_out = cur_inc;
			median     = med;
		end else begin
			ring_out   = ring_in;
			fill_out   = fill_in;
			cursor_out = cursor_in;
			median     = sample;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/pmef_lowpass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmef_lowpass
// One-pole low-pass step in Q12.16: s + alpha * ((m << 16) - s) >> 16,
// or a direct load of the median on the first value of a cell.
// ----------------------------------------------------------------------------
module pmef_lowpass
	import pmef_pkg::*;
(
	input  logic [SAMPLE_W-1:0] median,
	input  logic                started,
	input  logic [SMOOTH_W-1:0] smoothed_prev,
	input  logic [ALPHA_W-1:0]  alpha,
	output logic [SMOOTH_W-1:0] smoothed_next
);

	localparam int DIFF_W = SMOOTH_W + 1;
	localparam int PROD_W = DIFF_W + ALPHA_W + 1;
	localparam int STEP_W = PROD_W - FRAC_W;

	logic [SMOOTH_W-1:0]      target;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [STEP_W-1:0] step;
	logic signed [STEP_W-1:0] sum;

	assign target = {median, FRAC_W'(0)};
	assign diff   = $signed({1'b0, target}) - $signed({1'b0, smoothed_prev});
	assign prod   = $signed({1'b0, alpha}) * diff;
	// arithmetic shift keeps the floor of the weighted difference
	assign step   = prod[PROD_W-1:FRAC_W];
	assign sum    = $signed(STEP_W'(smoothed_prev)) + step;

	assign smoothed_next = started ? sum[SMOOTH_W-1:0] : target;

endmodule
`default_nettype wire

// File: hw/rtl/pmef_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmef_result_fifo
// Small result queue that decouples the filter pipeline from the result
// channel's stall.
// ----------------------------------------------------------------------------
module pmef_result_fifo
	import pmef_pkg::*;
#(
	parameter int DEPTH = RESULT_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [FILTERED_W-1:0]   push_data,
	output logic                    valid,
	input  logic                    stall,
	output logic [FILTERED_W-1:0]   data,
	output logic [RESULT_CNT_W-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [FILTERED_W-1:0]   mem [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [RESULT_CNT_W-1:0] count_q;
	logic                    pop;

	assign valid = (count_q != '0);
	assign pop   = valid && !stall;
	assign data  = mem[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + RESULT_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - RESULT_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/pmef_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmef_checker
// Port-level checks of the filter: result hold, clearing after register
// writes, and no result without an earlier request.
// ----------------------------------------------------------------------------
module pmef_checker
	import pmef_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input logic                  res_valid,
	input logic                  res_stall,
	input logic [FILTERED_W-1:0] filtered,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(filtered))
		else $error("result changed while stalled");

	// every register write starts a clearing pass that holds off requests
	a_clear_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> req_stall)
		else $error("request channel open right after a register write");

	// an empty queue fills only from an accepted request that has passed both stages
	a_res_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_valid && !req_stall, 3))
		else $error("result appeared without a matching request");

endmodule

bind per_sensor_median_ema_filter pmef_checker u_pmef_checker (.*);
`default_nettype wire
